>>> rtl/smi_pkg.sv
// ----------------------------------------------------------------------------
// smi_pkg - shared types and constants
// Widths and the request word from the sequencer to the determinant unit.
// ----------------------------------------------------------------------------
package smi_pkg;

	localparam int MAX_DIM_DEF   = 4;
	localparam int FRAC_BITS_DEF = 16;
	localparam int IDX_W         = 3;   // sizes and row/column indexes, up to 7
	localparam int ELEM_W        = 32;
	localparam int DET_W         = 64;
	localparam int QUOT_W        = 32;
	localparam int ACC_GUARD     = 12;  // sign plus growth over up to 720 terms

	typedef struct packed {
		logic             start;
		logic             rep_en;   // replace row rep_row by unit vector at rep_col
		logic [IDX_W-1:0] rep_row;
		logic [IDX_W-1:0] rep_col;
		logic [IDX_W-1:0] size;
	} det_req_t;

endpackage

>>> rtl/smi_det_unit.sv
// ----------------------------------------------------------------------------
// smi_det_unit - exact determinant by permutation sum
// Walks all index tuples, and for each permutation multiplies its elements
// limb by limb on one 32x32 multiplier, then adds the signed product.
// ----------------------------------------------------------------------------
module smi_det_unit #(
	parameter int MAX_DIM = smi_pkg::MAX_DIM_DEF,
	parameter int ACC_W   = smi_pkg::ELEM_W * MAX_DIM + smi_pkg::ACC_GUARD,
	parameter int ADDR_W  = $clog2(MAX_DIM * MAX_DIM)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  smi_pkg::det_req_t       req,
	output logic [ADDR_W-1:0]       rd_addr,
	input  logic [31:0]             rd_data,
	output logic                    done,
	output logic signed [ACC_W-1:0] det
);

	localparam int PROD_W = smi_pkg::ELEM_W * MAX_DIM;
	localparam int LIMB_W = $clog2(MAX_DIM);
	localparam int IW     = smi_pkg::IDX_W;
	localparam int AF_W   = 2 * IW + 1;

	typedef enum logic [2:0] {S_IDLE, S_TUPLE, S_FETCH, S_MUL, S_ACC} state_t;

	state_t                  state_q;
	logic [IW-1:0]           p_q [MAX_DIM];
	logic [IW-1:0]           p_nx [MAX_DIM];
	logic [IW-1:0]           k_q, n_q, rep_row_q, rep_col_q, pk;
	logic                    rep_en_q, sgn_q, done_q;
	logic [LIMB_W-1:0]       limb_q;
	logic [PROD_W-1:0]       prod_q;
	logic [31:0]             carry_q, emag;
	logic                    eneg, is_perm, parity, wrap, cy;
	logic signed [ACC_W-1:0] acc_q, term;
	logic [63:0]             mp;
	logic [AF_W-1:0]         addr_full;

	always_comb begin
		is_perm = 1'b1;
		parity  = 1'b0;
		for (int i = 0; i < MAX_DIM; i++) begin
			for (int j = i + 1; j < MAX_DIM; j++) begin
				if (IW'(j) < n_q) begin
					if (p_q[i] == p_q[j]) is_perm = 1'b0;
					if (p_q[i] > p_q[j]) parity = ~parity;
				end
			end
		end
	end

	always_comb begin
		cy = 1'b1;
		for (int i = 0; i < MAX_DIM; i++) begin
			p_nx[i] = p_q[i];
			if (IW'(i) < n_q && cy) begin
				if (p_q[i] == n_q - IW'(1)) begin
					p_nx[i] = '0;
				end else begin
					p_nx[i] = p_q[i] + IW'(1);
					cy      = 1'b0;
				end
			end
		end
		wrap = cy;
	end

	always_comb begin
		pk = '0;
		for (int i = 0; i < MAX_DIM; i++) begin
			if (k_q == IW'(i)) pk = p_q[i];
		end
		addr_full = AF_W'(k_q) * AF_W'(n_q) + AF_W'(pk);
		rd_addr   = addr_full[ADDR_W-1:0];
		if (rep_en_q && k_q == rep_row_q) begin
			eneg = 1'b0;
			emag = (pk == rep_col_q) ? 32'd1 : 32'd0;
		end else begin
			eneg = rd_data[31];
			emag = eneg ? (32'd0 - rd_data) : rd_data;
		end
		mp   = 64'(prod_q[31:0]) * 64'(emag) + 64'(carry_q);
		term = sgn_q ? -$signed(ACC_W'(prod_q)) : $signed(ACC_W'(prod_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			acc_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req.start) begin
						n_q       <= req.size;
						rep_en_q  <= req.rep_en;
						rep_row_q <= req.rep_row;
						rep_col_q <= req.rep_col;
						for (int i = 0; i < MAX_DIM; i++) p_q[i] <= '0;
						acc_q   <= '0;
						state_q <= S_TUPLE;
					end
				end
				S_TUPLE: begin
					if (is_perm) begin
						prod_q  <= PROD_W'(1);
						k_q     <= '0;
						sgn_q   <= parity;
						state_q <= S_FETCH;
					end else if (wrap) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						p_q <= p_nx;
					end
				end
				S_FETCH: begin
					limb_q  <= '0;
					carry_q <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q  <= {mp[31:0], prod_q[PROD_W-1:32]};
					carry_q <= mp[63:32];
					limb_q  <= limb_q + LIMB_W'(1);
					if (limb_q == LIMB_W'(MAX_DIM - 1)) begin
						sgn_q <= sgn_q ^ eneg;
						if (k_q == n_q - IW'(1)) begin
							state_q <= S_ACC;
						end else begin
							k_q     <= k_q + IW'(1);
							state_q <= S_FETCH;
						end
					end
				end
				S_ACC: begin
					acc_q <= acc_q + term;
					if (wrap) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						p_q     <= p_nx;
						state_q <= S_TUPLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign det  = acc_q;

endmodule

>>> rtl/smi_divider.sv
// ----------------------------------------------------------------------------
// smi_divider - restoring divider for one inverse element
// Computes floor((num << 2*FRAC_BITS) / den) on magnitudes, one quotient bit
// per cycle, and flags a quotient that does not fit 32 bits.
// ----------------------------------------------------------------------------
module smi_divider #(
	parameter int FRAC_BITS = smi_pkg::FRAC_BITS_DEF,
	parameter int ACC_W     = smi_pkg::ELEM_W * smi_pkg::MAX_DIM_DEF + smi_pkg::ACC_GUARD
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ACC_W-1:0]           num_mag,
	input  logic [ACC_W-1:0]           den_mag,
	output logic                       done,
	output logic [smi_pkg::QUOT_W-1:0] quot,
	output logic                       ovf
);

	localparam int QW = smi_pkg::QUOT_W;
	localparam int XW = ACC_W + 2 * FRAC_BITS + QW;
	localparam int CW = $clog2(QW);

	logic [XW-1:0]    num_x, den_x;
	logic [ACC_W:0]   t;
	logic             ge, busy_q, done_q, ovf_q;
	logic [ACC_W-1:0] rem_q;
	logic [QW-1:0]    low_q, quot_q;
	logic [CW-1:0]    cnt_q;

	always_comb begin
		num_x = XW'({num_mag, {(2 * FRAC_BITS){1'b0}}});
		den_x = XW'({den_mag, {QW{1'b0}}});
		t     = {rem_q, low_q[QW-1]};
		ge    = t >= {1'b0, den_mag};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				quot_q <= '0;
				cnt_q  <= '0;
				if (num_x >= den_x) begin
					ovf_q  <= 1'b1;
					done_q <= 1'b1;
				end else begin
					ovf_q  <= 1'b0;
					rem_q  <= num_x[QW +: ACC_W];
					low_q  <= num_x[QW-1:0];
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				rem_q  <= ge ? ACC_W'(t - {1'b0, den_mag}) : t[ACC_W-1:0];
				low_q  <= {low_q[QW-2:0], 1'b0};
				quot_q <= {quot_q[QW-2:0], ge};
				cnt_q  <= cnt_q + CW'(1);
				if (cnt_q == CW'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign ovf  = ovf_q;

endmodule

>>> rtl/small_matrix_inverse_adjugate.sv
// ----------------------------------------------------------------------------
// small_matrix_inverse_adjugate - square matrix inverse by adjugate
// Loads a matrix row-major, computes its exact determinant and cofactors,
// and streams out the inverse one element per word.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel: one word writes matrix_size (1..MAX_DIM, 0 reads as 1, larger
//   reads as MAX_DIM). Always ready; write only while the block is idle.
//   in channel: one element per word; last_element marks the final one.
//   in_ready is high while no matrix is being worked on. Loading takes a word
//   whenever in_valid and in_ready are both high.
//   out channel: n*n words in row-major order, last_result on the final one.
//   Each determinant or cofactor is a sum over all n! permutations, found by
//   walking all n^n index tuples; each permutation's product is formed limb by
//   limb on the single 32x32 multiplier and added once to the accumulator. A
//   singular matrix skips the cofactors.
//   A stalled receiver holds the sequencer at the next result; the output
//   register keeps its word until taken.
//   Reset: size 4, load count zero, nothing pending; no clearing pass.
// ----------------------------------------------------------------------------
module small_matrix_inverse_adjugate #(
	parameter int MAX_DIM   = smi_pkg::MAX_DIM_DEF,
	parameter int FRAC_BITS = smi_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [2:0]                 matrix_size,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [31:0]         element_value,
	input  logic                       last_element,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [31:0]         inverse_value,
	output logic signed [63:0]         determinant_value,
	output logic                       singular_flag,
	output logic                       saturated_flag,
	output logic                       last_result
);

	localparam int IW     = smi_pkg::IDX_W;
	localparam int ACC_W  = smi_pkg::ELEM_W * MAX_DIM + smi_pkg::ACC_GUARD;
	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SH_W   = ACC_W + FRAC_BITS;

	typedef enum logic [3:0] {
		T_IDLE, T_DET_GO, T_DET_WAIT, T_DET_FIN, T_COF_GO, T_COF_WAIT,
		T_DIV_GO, T_DIV_WAIT, T_OUT
	} state_t;

	state_t                  state_q;
	logic [IW-1:0]           size_q, size_n, n_q, r_q, c_q;
	logic [CNT_W-1:0]        lc_q, cap;
	logic [31:0]             store_q [DEPTH];
	logic [31:0]             rd_data_q;
	logic [ADDR_W-1:0]       rd_addr;
	smi_pkg::det_req_t       req;
	logic                    det_done, div_done, div_ovf;
	logic signed [ACC_W-1:0] det_res;
	logic [smi_pkg::QUOT_W-1:0] quot;
	logic                    det_neg_q, cof_neg_q, singular_q, det_sat_q;
	logic [ACC_W-1:0]        det_mag_q, cof_mag_q;
	logic [63:0]             det_out_q, dv, dout;
	logic [SH_W-1:0]         dsh;
	logic [7:0]              shamt;
	logic                    dsat, in_acc, out_free, last_idx, qneg, qsat;
	logic [31:0]             qval;
	logic                    out_valid_q, out_sing_q, out_sat_q, out_last_q;
	logic [31:0]             out_inv_q;
	logic [63:0]             out_det_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == T_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign last_idx  = (r_q == n_q - IW'(1)) && (c_q == n_q - IW'(1));

	always_comb begin
		if (size_q == '0) size_n = IW'(1);
		else if (size_q > IW'(MAX_DIM)) size_n = IW'(MAX_DIM);
		else size_n = size_q;
		cap = CNT_W'(size_n) * CNT_W'(size_n);
	end

	always_ff @(posedge clk) begin
		if (in_acc && lc_q < cap) store_q[lc_q[ADDR_W-1:0]] <= element_value;
		rd_data_q <= store_q[rd_addr];
	end

	always_comb begin
		req.start   = (state_q == T_DET_GO) || (state_q == T_COF_GO);
		req.rep_en  = (state_q == T_COF_GO);
		req.rep_row = c_q;
		req.rep_col = r_q;
		req.size    = n_q;
	end

	smi_det_unit #(.MAX_DIM(MAX_DIM), .ACC_W(ACC_W), .ADDR_W(ADDR_W)) u_det (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_addr (rd_addr),
		.rd_data (rd_data_q),
		.done    (det_done),
		.det     (det_res)
	);

	smi_divider #(.FRAC_BITS(FRAC_BITS), .ACC_W(ACC_W)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == T_DIV_GO),
		.num_mag (cof_mag_q),
		.den_mag (det_mag_q),
		.done    (div_done),
		.quot    (quot),
		.ovf     (div_ovf)
	);

	// determinant scaled to Q32.32, truncated toward zero on the magnitude
	always_comb begin
		shamt = 8'(n_q - IW'(2)) * 8'(FRAC_BITS);
		if (n_q == IW'(1)) dsh = SH_W'(det_mag_q) << FRAC_BITS;
		else dsh = SH_W'(det_mag_q) >> shamt;
		dv   = dsh[63:0];
		dsat = (|dsh[SH_W-1:64]) || (det_neg_q ? (dv > 64'h8000_0000_0000_0000) : dv[63]);
		if (dsat) dout = det_neg_q ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		else dout = det_neg_q ? (64'd0 - dv) : dv;
	end

	always_comb begin
		qneg = cof_neg_q ^ det_neg_q;
		qsat = div_ovf || (qneg ? (quot > 32'h8000_0000) : quot[31]);
		if (singular_q) qval = '0;
		else if (qsat) qval = qneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		else qval = qneg ? (32'd0 - quot) : quot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			size_q      <= IW'(4);
			lc_q        <= '0;
			det_out_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) size_q <= matrix_size;
			if (out_ready && state_q != T_OUT) out_valid_q <= 1'b0;
			unique case (state_q)
				T_IDLE: begin
					if (in_acc) begin
						if (last_element) begin
							lc_q    <= '0;
							n_q     <= size_n;
							state_q <= T_DET_GO;
						end else if (lc_q < cap) begin
							lc_q <= lc_q + CNT_W'(1);
						end
					end
				end
				T_DET_GO: state_q <= T_DET_WAIT;
				T_DET_WAIT: begin
					if (det_done) begin
						det_neg_q <= det_res[ACC_W-1];
						det_mag_q <= det_res[ACC_W-1] ? ACC_W'(-det_res) : ACC_W'(det_res);
						state_q   <= T_DET_FIN;
					end
				end
				T_DET_FIN: begin
					singular_q <= (det_mag_q == '0);
					det_out_q  <= dout;
					det_sat_q  <= dsat;
					r_q        <= '0;
					c_q        <= '0;
					state_q    <= (det_mag_q == '0) ? T_OUT : T_COF_GO;
				end
				T_COF_GO: state_q <= T_COF_WAIT;
				T_COF_WAIT: begin
					if (det_done) begin
						cof_neg_q <= det_res[ACC_W-1];
						cof_mag_q <= det_res[ACC_W-1] ? ACC_W'(-det_res) : ACC_W'(det_res);
						state_q   <= T_DIV_GO;
					end
				end
				T_DIV_GO: state_q <= T_DIV_WAIT;
				T_DIV_WAIT: if (div_done) state_q <= T_OUT;
				T_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_inv_q   <= qval;
						out_det_q   <= det_out_q;
						out_sing_q  <= singular_q;
						out_sat_q   <= det_sat_q || (!singular_q && qsat);
						out_last_q  <= last_idx;
						if (c_q == n_q - IW'(1)) begin
							c_q <= '0;
							r_q <= r_q + IW'(1);
						end else begin
							c_q <= c_q + IW'(1);
						end
						if (last_idx) state_q <= T_IDLE;
						else if (!singular_q) state_q <= T_COF_GO;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign out_valid         = out_valid_q;
	assign inverse_value     = out_inv_q;
	assign determinant_value = out_det_q;
	assign singular_flag     = out_sing_q;
	assign saturated_flag    = out_sat_q;
	assign last_result       = out_last_q;

	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular_flag |-> inverse_value == 32'd0 &&
			determinant_value == 64'd0 && !saturated_flag)
		else $error("singular word carries nonzero data");

	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last_element |=> !in_ready)
		else $error("input taken while computing");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == T_DIV_WAIT)
		else $error("divider finished outside its wait");

	a_det_done: assert property (@(posedge clk) disable iff (!arst_n)
		det_done |-> state_q == T_DET_WAIT || state_q == T_COF_WAIT)
		else $error("determinant finished outside its wait");

endmodule

>>> tb/inverse_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// inverse_checker - matrix inverse scoreboard
// Watches the cfg, in and out channels, keeps its own copy of the loaded
// matrix and size, computes the exact determinant and adjugate with wide
// integers, and compares every out word against the oldest expected word.
// ----------------------------------------------------------------------------
module inverse_checker (
	input  logic                            clk,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [2:0]                      matrix_size,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic signed [smi_pkg::ELEM_W-1:0] element_value,
	input  logic                            last_element,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic signed [smi_pkg::QUOT_W-1:0] inverse_value,
	input  logic signed [smi_pkg::DET_W-1:0]  determinant_value,
	input  logic                            singular_flag,
	input  logic                            saturated_flag,
	input  logic                            last_result,
	output int                              errors,
	output int                              pending
);
	localparam int MAXN = smi_pkg::MAX_DIM_DEF;
	localparam int FRAC = smi_pkg::FRAC_BITS_DEF;

	typedef logic signed [255:0] wide_t;

	typedef struct {
		logic [31:0] inv;
		logic [63:0] det;
		bit          sing;
		bit          sat;
		bit          last;
	} inverse_word_t;

	localparam wide_t MAX32 = 256'sd2147483647;
	localparam wide_t MIN32 = -MAX32 - 1;
	localparam wide_t MAX64 = 256'sd9223372036854775807;
	localparam wide_t MIN64 = -MAX64 - 1;

	logic [31:0]   mstore [MAXN*MAXN];
	int            fill = 0;
	int            size_code = 4;
	int            err_cnt = 0;
	inverse_word_t expected_words[$];

	function automatic wide_t minor_det(int n, int skip_r, int skip_c);
		int    rl[MAXN];
		int    cl[MAXN];
		int    p[MAXN];
		int    mr, mc, total, v, inv;
		bit    ok;
		wide_t acc, term;
		mr = 0;
		mc = 0;
		for (int i = 0; i < n; i++) begin
			if (i != skip_r) begin
				rl[mr] = i;
				mr++;
			end
			if (i != skip_c) begin
				cl[mc] = i;
				mc++;
			end
		end
		if (mr == 0)
			return 1;
		total = 1;
		for (int i = 0; i < mr; i++)
			total = total * mr;
		acc = 0;
		for (int t = 0; t < total; t++) begin
			v = t;
			for (int i = 0; i < mr; i++) begin
				p[i] = v % mr;
				v = v / mr;
			end
			ok = 1;
			inv = 0;
			for (int i = 0; i < mr; i++)
				for (int j = i + 1; j < mr; j++) begin
					if (p[i] == p[j])
						ok = 0;
					else if (p[i] > p[j])
						inv++;
				end
			if (ok) begin
				term = 1;
				for (int i = 0; i < mr; i++)
					term = term * $signed(mstore[rl[i]*n + cl[p[i]]]);
				if (inv % 2)
					acc = acc - term;
				else
					acc = acc + term;
			end
		end
		return acc;
	endfunction

	function automatic wide_t trunc_shr(wide_t x, int s);
		wide_t mag;
		mag = (x < 0) ? -x : x;
		mag = mag >> s;
		return (x < 0) ? -mag : mag;
	endfunction

	task automatic predict_inverse(int n);
		wide_t         det, dout, cof, q;
		bit            det_sat, sing;
		logic [63:0]   det_word;
		inverse_word_t w;
		det = minor_det(n, -1, -1);
		sing = (det == 0);
		dout = (n == 1) ? (det <<< FRAC) : trunc_shr(det, (n - 2) * FRAC);
		det_sat = 0;
		if (dout > MAX64) begin
			det_sat = 1;
			dout = MAX64;
		end else if (dout < MIN64) begin
			det_sat = 1;
			dout = MIN64;
		end
		det_word = dout[63:0];
		for (int r = 0; r < n; r++)
			for (int c = 0; c < n; c++) begin
				w.det = det_word;
				w.sing = sing;
				w.sat = det_sat;
				w.last = (r == n - 1) && (c == n - 1);
				w.inv = '0;
				if (!sing) begin
					cof = minor_det(n, c, r);
					if ((r + c) % 2)
						cof = -cof;
					q = (cof <<< (2 * FRAC)) / det;
					if (q > MAX32) begin
						w.sat = 1;
						q = MAX32;
					end else if (q < MIN32) begin
						w.sat = 1;
						q = MIN32;
					end
					w.inv = q[31:0];
				end
				expected_words.push_back(w);
			end
	endtask

	always @(posedge clk) begin
		int            n;
		inverse_word_t e;
		if (cfg_valid && cfg_ready)
			size_code = matrix_size;
		if (in_valid && in_ready) begin
			n = (size_code < 1) ? 1 : (size_code > MAXN) ? MAXN : size_code;
			if (fill < n * n) begin
				mstore[fill] = element_value;
				fill++;
			end
			if (last_element) begin
				fill = 0;
				predict_inverse(n);
			end
		end
		if (out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word inverse %h det %h", $time,
					inverse_value, determinant_value);
				err_cnt++;
			end else begin
				e = expected_words.pop_front();
				if (inverse_value !== e.inv) begin
					$display("%0t: inverse_value exp %h got %h", $time, e.inv, inverse_value);
					err_cnt++;
				end
				if (determinant_value !== e.det) begin
					$display("%0t: determinant_value exp %h got %h", $time, e.det,
						determinant_value);
					err_cnt++;
				end
				if (singular_flag !== e.sing) begin
					$display("%0t: singular_flag exp %b got %b", $time, e.sing, singular_flag);
					err_cnt++;
				end
				if (saturated_flag !== e.sat) begin
					$display("%0t: saturated_flag exp %b got %b", $time, e.sat,
						saturated_flag);
					err_cnt++;
				end
				if (last_result !== e.last) begin
					$display("%0t: last_result exp %b got %b", $time, e.last, last_result);
					err_cnt++;
				end
			end
		end
		errors <= err_cnt;
		pending <= expected_words.size();
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - matrix inverse testbench
// Drives size writes and matrices of every size with random gaps and
// receiver stalls: directed extremes, 1x1, singular, tiny determinant,
// overlong, short and resized loads, then random matrices.
// ----------------------------------------------------------------------------
module tb_top;
	localparam int LIMIT = 200000;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  matrix_size;
	logic        in_valid;
	logic        in_ready;
	logic signed [31:0] element_value;
	logic        last_element;
	logic        out_valid;
	logic        out_ready;
	logic signed [31:0] inverse_value;
	logic signed [63:0] determinant_value;
	logic        singular_flag;
	logic        saturated_flag;
	logic        last_result;
	int          errors;
	int          pending;
	bit          calm;
	int          stall_left;
	int          idle_cycles = 0;
	int          items_sent;
	logic [31:0] vals [16];

	small_matrix_inverse_adjugate DUT (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .matrix_size, .in_valid, .in_ready,
		.element_value, .last_element, .out_valid, .out_ready, .inverse_value,
		.determinant_value, .singular_flag, .saturated_flag, .last_result
	);

	inverse_checker u_checker (
		.clk, .cfg_valid, .cfg_ready, .matrix_size, .in_valid, .in_ready,
		.element_value, .last_element, .out_valid, .out_ready, .inverse_value,
		.determinant_value, .singular_flag, .saturated_flag, .last_result,
		.errors, .pending
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		int r;
		if (!arst_n) begin
			out_ready <= 0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 0;
		end else if (calm) begin
			out_ready <= 1;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 65) begin
				out_ready <= 1;
			end else begin
				stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
				out_ready <= 0;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic put_word(logic [31:0] v, bit last);
		int r;
		in_valid <= 1;
		element_value <= v;
		last_element <= last;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		r = $urandom_range(0, 99);
		if (!calm && r >= 55) begin
			in_valid <= 0;
			repeat ((r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_size(logic [2:0] code);
		wait_idle();
		cfg_valid <= 1;
		matrix_size <= code;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
	endtask

	task automatic send_vals(int cnt);
		for (int i = 0; i < cnt; i++)
			put_word(vals[i], i == cnt - 1);
	endtask

	function automatic logic [31:0] rand_elem();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return $urandom_range(0, 32'h3FFFF) - 32'h20000;
		if (r < 80)
			return $urandom;
		case ($urandom_range(0, 5))
			0: return 32'h0;
			1: return 32'h1;
			2: return 32'h7FFFFFFF;
			3: return 32'h80000000;
			4: return 32'h00010000;
			default: return 32'hFFFF0000;
		endcase
	endfunction

	initial begin
		int n, kind, cnt;
		logic [2:0] code;
		arst_n = 0;
		cfg_valid = 0;
		matrix_size = 3'd4;
		in_valid = 0;
		element_value = '0;
		last_element = 0;
		calm = 1;
		items_sent = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// full 4x4 at reset size, fills every store entry
		for (int i = 0; i < 16; i++)
			vals[i] = (i % 5 == 0) ? 32'h00010000 + i : $urandom_range(0, 32'hFFFF);
		vals[1] = 32'h7FFFFFFF;
		vals[6] = 32'h80000000;
		send_vals(16);

		// 1x1: unit, tiny raw value, most negative value, zero
		write_size(3'd1);
		calm = 0;
		vals[0] = 32'h00010000;
		send_vals(1);
		vals[0] = 32'h1;
		send_vals(1);
		vals[0] = 32'h80000000;
		send_vals(1);
		vals[0] = 32'h0;
		send_vals(1);

		// size change while partially loaded
		write_size(3'd2);
		put_word(32'h00020000, 0);
		put_word(32'h00001000, 0);
		write_size(3'd3);
		for (int i = 0; i < 7; i++)
			put_word(rand_elem(), i == 6);

		while (items_sent < 205) begin
			kind = $urandom_range(0, 99);
			n = kind < 20 ? 1 : kind < 60 ? 2 : kind < 90 ? 3 : 4;
			code = n;
			if (n == 1 && $urandom_range(0, 2) == 0)
				code = 3'd0;
			if (n == 4 && $urandom_range(0, 1) == 0)
				code = $urandom_range(5, 7);
			write_size(code);
			calm = ($urandom_range(0, 4) == 0);
			for (int i = 0; i < 16; i++)
				vals[i] = rand_elem();
			cnt = n * n;
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
			end else if (kind < 78) begin
				if (n == 1)
					vals[0] = 0;
				for (int c = 0; c < n && n > 1; c++)
					vals[n + c] = vals[c];
			end else if (kind < 84) begin
				for (int i = 0; i < 16; i++)
					vals[i] = (i % (n + 1) == 0 && i < n * n) ? 32'h1 : 32'h0;
			end else if (kind < 92) begin
				cnt = n * n + $urandom_range(1, 3);
			end else if (n > 1) begin
				cnt = $urandom_range(1, n * n - 1);
			end
			send_vals(cnt);
		end

		wait_idle();
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
